>>> hw/rtl/c2s_pkg.sv
// Shared constants and the arctangent table for the Cartesian to spherical converter.
package c2s_pkg;

  // Default geometry of the top level.
  localparam int unsigned COORD_WIDTH_DEF  = 18;
  localparam int unsigned ANGLE_WIDTH_DEF  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  // Fractional guard bits on coordinates and headroom bits for CORDIC growth.
  localparam int unsigned GUARD    = 8;
  localparam int unsigned HEADROOM = 3;

  // Internal angle: pi is 2^31, kept in 34 bits for the pre-rotation plus the sum of steps.
  localparam int unsigned ANG_UNIT_SHIFT = 31;
  localparam int unsigned ANG_INT_WIDTH  = 34;
  localparam logic signed [ANG_INT_WIDTH-1:0] ANG_PI = 34'sh0_8000_0000;

  // Inverse CORDIC gain, round(0.6072529350088813 * 2^20).
  localparam int unsigned INV_GAIN_SHIFT = 20;
  localparam int unsigned INV_GAIN_WIDTH = 20;
  localparam logic [INV_GAIN_WIDTH-1:0] INV_GAIN = 20'd636751;

  // atan(2^-i) in internal angle units.
  localparam int unsigned TABLE_LEN = 24;
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

>>> hw/rtl/c2s_rot_cell.sv
// One vectoring CORDIC iteration: rotate toward the x axis by atan(2^-STEP), then register.
module c2s_rot_cell #(
  parameter int unsigned DW   = c2s_pkg::COORD_WIDTH_DEF + c2s_pkg::GUARD + c2s_pkg::HEADROOM,
  parameter int unsigned SW   = 1,
  parameter int unsigned STEP = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [DW-1:0]                     x_i,
  input  logic signed [DW-1:0]                     y_i,
  input  logic signed [c2s_pkg::ANG_INT_WIDTH-1:0] ang_i,
  input  logic [SW-1:0]                            side_i,
  output logic                                     valid_o,
  output logic signed [DW-1:0]                     x_o,
  output logic signed [DW-1:0]                     y_o,
  output logic signed [c2s_pkg::ANG_INT_WIDTH-1:0] ang_o,
  output logic [SW-1:0]                            side_o
);

  localparam int unsigned AWI = c2s_pkg::ANG_INT_WIDTH;
  localparam logic signed [AWI-1:0] ATAN_STEP = AWI'(c2s_pkg::ATAN_TAB[STEP]);

  logic                  valid_q;
  logic signed [DW-1:0]  x_q, y_q, x_d, y_d, x_sh, y_sh;
  logic signed [AWI-1:0] ang_q, ang_d;
  logic [SW-1:0]         side_q;

  // Rotate by the sign of y; shifts are arithmetic (floor).
  always_comb begin
    x_sh = x_i >>> STEP;
    y_sh = y_i >>> STEP;
    if (y_i[DW-1]) begin
      x_d   = x_i - y_sh;
      y_d   = y_i + x_sh;
      ang_d = ang_i - ATAN_STEP;
    end else begin
      x_d   = x_i + y_sh;
      y_d   = y_i - x_sh;
      ang_d = ang_i + ATAN_STEP;
    end
  end

  // Advance the valid bit with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Hold the payload while the pipeline is stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      ang_q  <= ang_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign ang_o   = ang_q;
  assign side_o  = side_q;

endmodule

>>> hw/rtl/c2s_gain_cell.sv
// Gain correction cell: scale the CORDIC magnitude by the inverse gain, rounded, then register.
module c2s_gain_cell #(
  parameter int unsigned DW = c2s_pkg::COORD_WIDTH_DEF + c2s_pkg::GUARD + c2s_pkg::HEADROOM,
  parameter int unsigned SW = 1
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [DW-1:0]                     x_i,
  input  logic signed [c2s_pkg::ANG_INT_WIDTH-1:0] ang_i,
  input  logic [SW-1:0]                            side_i,
  output logic                                     valid_o,
  output logic signed [DW-1:0]                     mag_o,
  output logic signed [c2s_pkg::ANG_INT_WIDTH-1:0] ang_o,
  output logic [SW-1:0]                            side_o
);

  localparam int unsigned AWI = c2s_pkg::ANG_INT_WIDTH;
  localparam int unsigned IGW = c2s_pkg::INV_GAIN_WIDTH;
  localparam int unsigned PW  = DW - 1 + IGW;
  localparam logic [PW-1:0] ROUND_HALF = PW'(64'd1 << (c2s_pkg::INV_GAIN_SHIFT - 1));

  logic                  valid_q;
  logic [DW-2:0]         mag_clip;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         prod_rnd;
  logic signed [DW-1:0]  mag_q, mag_d;
  logic signed [AWI-1:0] ang_q;
  logic [SW-1:0]         side_q;

  // Clamp negatives to zero, multiply, round half up and drop the fraction.
  always_comb begin
    mag_clip = x_i[DW-1] ? '0 : x_i[DW-2:0];
    prod     = PW'(mag_clip) * PW'(c2s_pkg::INV_GAIN);
    prod_rnd = prod + ROUND_HALF;
    mag_d    = {1'b0, prod_rnd[c2s_pkg::INV_GAIN_SHIFT +: DW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      ang_q  <= ang_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign ang_o   = ang_q;
  assign side_o  = side_q;

endmodule

>>> hw/rtl/c2s_vector_chain.sv
// Vectoring CORDIC: half-plane pre-rotation stage, a row of rotation cells, then gain correction.
module c2s_vector_chain #(
  parameter int unsigned DW    = c2s_pkg::COORD_WIDTH_DEF + c2s_pkg::GUARD + c2s_pkg::HEADROOM,
  parameter int unsigned SW    = 1,
  parameter int unsigned STEPS = c2s_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [DW-1:0]                     x_i,
  input  logic signed [DW-1:0]                     y_i,
  input  logic [SW-1:0]                            side_i,
  output logic                                     valid_o,
  output logic signed [DW-1:0]                     mag_o,
  output logic signed [c2s_pkg::ANG_INT_WIDTH-1:0] ang_o,
  output logic [SW-1:0]                            side_o
);

  localparam int unsigned AWI   = c2s_pkg::ANG_INT_WIDTH;
  localparam int unsigned NCELL = (STEPS < c2s_pkg::TABLE_LEN) ? STEPS : c2s_pkg::TABLE_LEN;

  logic                  vld_s  [NCELL+1];
  logic signed [DW-1:0]  x_s    [NCELL+1];
  logic signed [DW-1:0]  y_s    [NCELL+1];
  logic signed [AWI-1:0] ang_s  [NCELL+1];
  logic [SW-1:0]         side_s [NCELL+1];

  logic                  pre_valid_q;
  logic signed [DW-1:0]  pre_x_q, pre_y_q, pre_x_d, pre_y_d;
  logic signed [AWI-1:0] pre_ang_q, pre_ang_d;
  logic [SW-1:0]         pre_side_q;

  // Turn a vector in the left half plane by pi so the cells see x >= 0.
  always_comb begin
    if (x_i[DW-1]) begin
      pre_x_d   = -x_i;
      pre_y_d   = -y_i;
      pre_ang_d = y_i[DW-1] ? -c2s_pkg::ANG_PI : c2s_pkg::ANG_PI;
    end else begin
      pre_x_d   = x_i;
      pre_y_d   = y_i;
      pre_ang_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (en_i) begin
      pre_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_x_q    <= pre_x_d;
      pre_y_q    <= pre_y_d;
      pre_ang_q  <= pre_ang_d;
      pre_side_q <= side_i;
    end
  end

  assign vld_s[0]  = pre_valid_q;
  assign x_s[0]    = pre_x_q;
  assign y_s[0]    = pre_y_q;
  assign ang_s[0]  = pre_ang_q;
  assign side_s[0] = pre_side_q;

  // Row of rotation cells, one per CORDIC iteration.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    c2s_rot_cell #(
      .DW  (DW),
      .SW  (SW),
      .STEP(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .valid_i(vld_s[i]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .ang_i  (ang_s[i]),
      .side_i (side_s[i]),
      .valid_o(vld_s[i+1]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .ang_o  (ang_s[i+1]),
      .side_o (side_s[i+1])
    );
  end

  // Remove the CORDIC gain from the final x.
  c2s_gain_cell #(
    .DW(DW),
    .SW(SW)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(vld_s[NCELL]),
    .x_i    (x_s[NCELL]),
    .ang_i  (ang_s[NCELL]),
    .side_i (side_s[NCELL]),
    .valid_o(valid_o),
    .mag_o  (mag_o),
    .ang_o  (ang_o),
    .side_o (side_o)
  );

endmodule

>>> hw/rtl/cartesian_to_spherical.sv
// Top level: Cartesian point to radius, inclination and azimuth through two chained CORDICs.
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  coord_x_i, coord_y_i, coord_z_i
//   out      out_valid_o/out_ready_i radius_o, inclination_o, azimuth_o, zero_vector_o
//
// One item enters per cycle while in_ready_o is high; a result passes the two rows of CORDIC
// cells, each with a pre-rotation and a gain stage, and then the output register.
// Reset clears all valid bits; no clearing pass, the block is ready right after reset.
// An output register plus a skid register decouple the sides; when the skid register
// fills, in_ready_o drops and the whole pipeline holds until the result drains.
module cartesian_to_spherical #(
  parameter int unsigned COORD_WIDTH  = c2s_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH  = c2s_pkg::ANGLE_WIDTH_DEF,
  parameter int unsigned CORDIC_STEPS = c2s_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic signed [COORD_WIDTH-1:0] coord_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_WIDTH-1:0]        radius_o,
  output logic [ANGLE_WIDTH-1:0]        inclination_o,
  output logic signed [ANGLE_WIDTH-1:0] azimuth_o,
  output logic                          zero_vector_o
);

  localparam int unsigned GUARD = c2s_pkg::GUARD;
  localparam int unsigned HR    = c2s_pkg::HEADROOM;
  localparam int unsigned DW    = COORD_WIDTH + GUARD + HR;
  localparam int unsigned AWI   = c2s_pkg::ANG_INT_WIDTH;
  localparam int unsigned SW1   = COORD_WIDTH + 2;
  localparam int unsigned SW2   = ANGLE_WIDTH + 1;
  localparam int unsigned RSH   = c2s_pkg::ANG_UNIT_SHIFT + 1 - ANGLE_WIDTH;
  localparam int unsigned RW    = DW - GUARD;
  localparam logic signed [AWI-1:0] ANG_HALF = AWI'(64'sd1 <<< (RSH - 1));
  localparam logic signed [AWI-1:0] INCL_MAX = AWI'(64'sd1 <<< (ANGLE_WIDTH - 1));
  localparam logic [DW-1:0]         RAD_HALF = DW'(64'd1 << (GUARD - 1));

  typedef struct packed {
    logic [COORD_WIDTH-1:0]        radius;
    logic [ANGLE_WIDTH-1:0]        incl;
    logic signed [ANGLE_WIDTH-1:0] azim;
    logic                          zero;
  } result_t;

  logic en;

  // First CORDIC: (x, y) to planar length and azimuth; z and flags ride along.
  logic                  c1_valid;
  logic signed [DW-1:0]  c1_x, c1_y, c1_mag;
  logic signed [AWI-1:0] c1_ang;
  logic [SW1-1:0]        c1_side_in, c1_side;
  logic                  in_zero, in_xy_zero;

  assign in_xy_zero = (coord_x_i == '0) && (coord_y_i == '0);
  assign in_zero    = in_xy_zero && (coord_z_i == '0);
  assign c1_x       = {{HR{coord_x_i[COORD_WIDTH-1]}}, coord_x_i, {GUARD{1'b0}}};
  assign c1_y       = {{HR{coord_y_i[COORD_WIDTH-1]}}, coord_y_i, {GUARD{1'b0}}};
  assign c1_side_in = {in_zero, in_xy_zero, coord_z_i};

  c2s_vector_chain #(
    .DW   (DW),
    .SW   (SW1),
    .STEPS(CORDIC_STEPS)
  ) u_chain_xy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .x_i    (c1_x),
    .y_i    (c1_y),
    .side_i (c1_side_in),
    .valid_o(c1_valid),
    .mag_o  (c1_mag),
    .ang_o  (c1_ang),
    .side_o (c1_side)
  );

  // Round azimuth; a point on the z axis has no planar length and azimuth zero.
  logic signed [AWI-1:0]         phi_full;
  logic signed [ANGLE_WIDTH-1:0] phi;
  logic                          mid_zero, mid_xy_zero;
  logic signed [COORD_WIDTH-1:0] mid_z;
  logic signed [DW-1:0]          c2_x, c2_y, c2_mag;
  logic [SW2-1:0]                c2_side_in, c2_side;
  logic                          c2_valid;
  logic signed [AWI-1:0]         c2_ang;

  assign {mid_zero, mid_xy_zero, mid_z} = c1_side;

  always_comb begin
    phi_full   = (c1_ang + ANG_HALF) >>> RSH;
    phi        = mid_xy_zero ? '0 : phi_full[ANGLE_WIDTH-1:0];
    c2_x       = {{HR{mid_z[COORD_WIDTH-1]}}, mid_z, {GUARD{1'b0}}};
    c2_y       = mid_xy_zero ? '0 : c1_mag;
    c2_side_in = {mid_zero, phi};
  end

  // Second CORDIC: (z, planar length) to radius and inclination.
  c2s_vector_chain #(
    .DW   (DW),
    .SW   (SW2),
    .STEPS(CORDIC_STEPS)
  ) u_chain_rz (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(c1_valid),
    .x_i    (c2_x),
    .y_i    (c2_y),
    .side_i (c2_side_in),
    .valid_o(c2_valid),
    .mag_o  (c2_mag),
    .ang_o  (c2_ang),
    .side_o (c2_side)
  );

  // Round and clamp inclination, round and saturate radius, force zeros for the zero vector.
  logic signed [AWI-1:0] theta_full;
  logic [DW-1:0]         rad_sum;
  logic [RW-1:0]         rad_full;
  result_t               res;

  always_comb begin
    theta_full = (c2_ang + ANG_HALF) >>> RSH;
    rad_sum    = c2_mag + RAD_HALF;
    rad_full   = rad_sum[DW-1:GUARD];
    res.zero   = c2_side[SW2-1];
    res.azim   = res.zero ? '0 : c2_side[ANGLE_WIDTH-1:0];
    if (res.zero || theta_full[AWI-1]) begin
      res.incl = '0;
    end else if (theta_full > INCL_MAX) begin
      res.incl = INCL_MAX[ANGLE_WIDTH-1:0];
    end else begin
      res.incl = theta_full[ANGLE_WIDTH-1:0];
    end
    if (res.zero) begin
      res.radius = '0;
    end else if (|rad_full[RW-1:COORD_WIDTH]) begin
      res.radius = '1;
    end else begin
      res.radius = rad_full[COORD_WIDTH-1:0];
    end
  end

  // Output register with skid stage; the pipeline holds only while the skid is full.
  logic    out_valid_q, skid_valid_q, take;
  result_t out_q, skid_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign take       = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (c2_valid) begin
      if (out_valid_q && !out_ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (c2_valid) begin
      if (out_valid_q && !out_ready_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign radius_o      = out_q.radius;
  assign inclination_o = out_q.incl;
  assign azimuth_o     = out_q.azim;
  assign zero_vector_o = out_q.zero;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid register filled without an output stall");

  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_vector_o) |->
      (radius_o == '0 && inclination_o == '0 && azimuth_o == '0))
    else $error("zero vector item with nonzero fields");

  a_incl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (AWI'(inclination_o) <= INCL_MAX))
    else $error("inclination above pi");
`endif

endmodule
